// File: sv/nrp_pkg.sv
// Shared types, codes and constants of the NAL unit RTP payload packetizer.
package nrp_pkg;

   // Size field width taken from nal_size and next_size
   localparam int LengthBits = 16;
   localparam logic [15:0] SizeMask = 16'((32'd1 << LengthBits) - 1);

   // Payload limit register
   localparam logic [15:0] ResetLimit = 16'd1400;
   localparam logic [15:0] MinLimit   = 16'd16;

   // Most results one transaction can cause
   localparam int MaxResults = 6;
   localparam int CountBits  = 3;

   // Payload header bytes
   localparam logic [7:0] ApType   = 8'd48;
   localparam logic [7:0] FuType   = 8'd49;
   localparam logic [7:0] TypeMask = 8'h3F;
   localparam logic [7:0] SBit     = 8'h80;
   localparam logic [7:0] EBit     = 8'h40;

   // Request function codes
   localparam logic FuncData  = 1'b0;
   localparam logic FuncFlush = 1'b1;

   // Packet kind codes
   localparam logic [1:0] KindSingle = 2'd0;
   localparam logic [1:0] KindAgg    = 2'd1;
   localparam logic [1:0] KindFrag   = 2'd2;

   // Unit handling state
   typedef enum logic [3:0] {
      ModeIdle   = 4'b0001,
      ModeSingle = 4'b0010,
      ModeAgg    = 4'b0100,
      ModeFrag   = 4'b1000
   } mode_type;

   // One result transaction
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        packet_end;
      logic [1:0]  packet_kind;
      logic [15:0] seq_number;
      logic        last_of_step;
   } result_type;

   // All results of one request transaction
   typedef struct packed {
      result_type [MaxResults-1:0] item;
      logic [CountBits-1:0]        count;
   } burst_type;

   function automatic result_type make_result(input logic [7:0] b, input logic valid,
                                              input logic pend, input logic [1:0] kind,
                                              input logic [15:0] seq);
      result_type r;
      r.out_byte     = b;
      r.byte_valid   = valid;
      r.packet_end   = pend;
      r.packet_kind  = kind;
      r.seq_number   = seq;
      r.last_of_step = 1'b0;
      return r;
   endfunction

endpackage

// File: sv/nrp_engine.sv
// Packetizer state and the single-pass step logic that builds all results of one transaction.
module nrp_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                func,
   input  logic [7:0]          data_byte,
   input  logic                first_of_nal,
   input  logic [15:0]         nal_size,
   input  logic [15:0]         next_size,
   input  logic [15:0]         limit,
   output nrp_pkg::burst_type  step
);

   nrp_pkg::mode_type mode_ff, mode_in;
   logic        agg_open_ff, agg_open_in;
   logic [15:0] agg_len_ff, agg_len_in;
   logic [15:0] byte_pos_ff, byte_pos_in;
   logic [15:0] unit_len_ff, unit_len_in;
   logic [15:0] fill_ff, fill_in;
   logic [5:0]  unit_type_ff, unit_type_in;
   logic [15:0] seq_ff, seq_in;

   // Step logic: mirrors the per-byte packetizing decisions in one pass
   always_comb begin
      logic [15:0] n;
      logic [15:0] nx;
      logic [15:0] lim;
      logic [15:0] maxd;
      logic [15:0] seq;
      logic [16:0] pos_inc;
      logic [15:0] fill;
      logic        done;
      logic        last_frag;
      logic [nrp_pkg::CountBits-1:0] cnt;

      mode_in      = mode_ff;
      agg_open_in  = agg_open_ff;
      agg_len_in   = agg_len_ff;
      byte_pos_in  = byte_pos_ff;
      unit_len_in  = unit_len_ff;
      fill_in      = fill_ff;
      unit_type_in = unit_type_ff;
      step         = '0;
      cnt          = '0;
      seq          = seq_ff;
      fill         = fill_ff;
      last_frag    = 1'b0;

      n = nal_size & nrp_pkg::SizeMask;
      if (n == 16'd0) begin
         n = 16'd1;
      end
      nx      = next_size & nrp_pkg::SizeMask;
      lim     = (limit < nrp_pkg::MinLimit) ? nrp_pkg::MinLimit : limit;
      maxd    = lim - 16'd3;
      pos_inc = {1'b0, byte_pos_ff} + 17'd1;
      done    = (pos_inc >= {1'b0, unit_len_ff});

      if (accept) begin
         if (func == nrp_pkg::FuncFlush) begin
            // flush closes an open aggregation packet between units
            if (mode_ff == nrp_pkg::ModeIdle && agg_open_ff) begin
               step.item[cnt] = nrp_pkg::make_result(8'd0, 1'b0, 1'b1, nrp_pkg::KindAgg, seq);
               cnt = cnt + 1'b1;
               seq = seq + 16'd1;
               agg_open_in = 1'b0;
               agg_len_in  = 16'd0;
            end
         end else if (mode_ff == nrp_pkg::ModeIdle) begin
            // first byte of a unit picks the packet form
            if (first_of_nal) begin
               unit_len_in = n;
               byte_pos_in = 16'd1;
               if (n >= lim) begin
                  if (agg_open_ff) begin
                     step.item[cnt] = nrp_pkg::make_result(8'd0, 1'b0, 1'b1,
                                                           nrp_pkg::KindAgg, seq);
                     cnt = cnt + 1'b1;
                     seq = seq + 16'd1;
                     agg_open_in = 1'b0;
                     agg_len_in  = 16'd0;
                  end
                  mode_in = nrp_pkg::ModeFrag;
                  fill_in = 16'd0;
               end else begin
                  // close the open aggregation when this unit does not fit
                  if (agg_open_in &&
                      ({2'b00, agg_len_in} + 18'd2 + {2'b00, n} > {2'b00, lim})) begin
                     step.item[cnt] = nrp_pkg::make_result(8'd0, 1'b0, 1'b1,
                                                           nrp_pkg::KindAgg, seq);
                     cnt = cnt + 1'b1;
                     seq = seq + 16'd1;
                     agg_open_in = 1'b0;
                     agg_len_in  = 16'd0;
                  end
                  // open a new aggregation when this and the next unit fit together
                  if (!agg_open_in && nx != 16'd0 &&
                      (18'd6 + {2'b00, n} + {2'b00, nx} <= {2'b00, lim})) begin
                     step.item[cnt] = nrp_pkg::make_result(8'd0, 1'b1, 1'b0,
                                                           nrp_pkg::KindAgg, seq);
                     cnt = cnt + 1'b1;
                     step.item[cnt] = nrp_pkg::make_result(nrp_pkg::ApType, 1'b1, 1'b0,
                                                           nrp_pkg::KindAgg, seq);
                     cnt = cnt + 1'b1;
                     agg_open_in = 1'b1;
                     agg_len_in  = 16'd2;
                  end
                  if (agg_open_in) begin
                     step.item[cnt] = nrp_pkg::make_result(8'(n >> 8), 1'b1, 1'b0,
                                                           nrp_pkg::KindAgg, seq);
                     cnt = cnt + 1'b1;
                     step.item[cnt] = nrp_pkg::make_result(n[7:0], 1'b1, 1'b0,
                                                           nrp_pkg::KindAgg, seq);
                     cnt = cnt + 1'b1;
                     step.item[cnt] = nrp_pkg::make_result(data_byte, 1'b1, 1'b0,
                                                           nrp_pkg::KindAgg, seq);
                     cnt = cnt + 1'b1;
                     agg_len_in = agg_len_in + 16'd2 + n;
                     mode_in = (n == 16'd1) ? nrp_pkg::ModeIdle : nrp_pkg::ModeAgg;
                  end else if (n == 16'd1) begin
                     step.item[cnt] = nrp_pkg::make_result(data_byte, 1'b1, 1'b1,
                                                           nrp_pkg::KindSingle, seq);
                     cnt = cnt + 1'b1;
                     seq = seq + 16'd1;
                     mode_in = nrp_pkg::ModeIdle;
                  end else begin
                     step.item[cnt] = nrp_pkg::make_result(data_byte, 1'b1, 1'b0,
                                                           nrp_pkg::KindSingle, seq);
                     cnt = cnt + 1'b1;
                     mode_in = nrp_pkg::ModeSingle;
                  end
               end
            end
         end else begin
            // later bytes of a unit; a first mark here is ignored
            case (mode_ff)
               nrp_pkg::ModeSingle: begin
                  step.item[cnt] = nrp_pkg::make_result(data_byte, 1'b1, done,
                                                        nrp_pkg::KindSingle, seq);
                  cnt = cnt + 1'b1;
                  if (done) begin
                     seq = seq + 16'd1;
                  end
               end
               nrp_pkg::ModeAgg: begin
                  step.item[cnt] = nrp_pkg::make_result(data_byte, 1'b1, 1'b0,
                                                        nrp_pkg::KindAgg, seq);
                  cnt = cnt + 1'b1;
               end
               nrp_pkg::ModeFrag: begin
                  if (byte_pos_ff == 16'd0) begin
                     // unit header byte 0 is dropped
                  end else if (byte_pos_ff == 16'd1) begin
                     // unit header byte 1 gives the type; first fragment headers go out
                     unit_type_in = data_byte[5:0];
                     last_frag = ((unit_len_ff - 16'd2) <= maxd);
                     step.item[cnt] = nrp_pkg::make_result(8'd0, 1'b1, 1'b0,
                                                           nrp_pkg::KindFrag, seq);
                     cnt = cnt + 1'b1;
                     step.item[cnt] = nrp_pkg::make_result(nrp_pkg::FuType, 1'b1, 1'b0,
                                                           nrp_pkg::KindFrag, seq);
                     cnt = cnt + 1'b1;
                     step.item[cnt] = nrp_pkg::make_result(
                        nrp_pkg::SBit | (last_frag ? nrp_pkg::EBit : 8'd0) |
                        ({2'b00, data_byte[5:0]} & nrp_pkg::TypeMask),
                        1'b1, 1'b0, nrp_pkg::KindFrag, seq);
                     cnt = cnt + 1'b1;
                     fill_in = 16'd0;
                  end else begin
                     fill = fill_ff + 16'd1;
                     fill_in = fill;
                     if (done) begin
                        step.item[cnt] = nrp_pkg::make_result(data_byte, 1'b1, 1'b1,
                                                              nrp_pkg::KindFrag, seq);
                        cnt = cnt + 1'b1;
                        seq = seq + 16'd1;
                        fill_in = 16'd0;
                     end else if (fill >= maxd) begin
                        // fragment full: close it and open the next one
                        step.item[cnt] = nrp_pkg::make_result(data_byte, 1'b1, 1'b1,
                                                              nrp_pkg::KindFrag, seq);
                        cnt = cnt + 1'b1;
                        seq = seq + 16'd1;
                        last_frag = ((unit_len_ff - pos_inc[15:0]) <= maxd);
                        step.item[cnt] = nrp_pkg::make_result(8'd0, 1'b1, 1'b0,
                                                              nrp_pkg::KindFrag, seq);
                        cnt = cnt + 1'b1;
                        step.item[cnt] = nrp_pkg::make_result(nrp_pkg::FuType, 1'b1, 1'b0,
                                                              nrp_pkg::KindFrag, seq);
                        cnt = cnt + 1'b1;
                        step.item[cnt] = nrp_pkg::make_result(
                           (last_frag ? nrp_pkg::EBit : 8'd0) |
                           ({2'b00, unit_type_ff} & nrp_pkg::TypeMask),
                           1'b1, 1'b0, nrp_pkg::KindFrag, seq);
                        cnt = cnt + 1'b1;
                        fill_in = 16'd0;
                     end else begin
                        step.item[cnt] = nrp_pkg::make_result(data_byte, 1'b1, 1'b0,
                                                              nrp_pkg::KindFrag, seq);
                        cnt = cnt + 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
            byte_pos_in = pos_inc[15:0];
            if (done) begin
               mode_in     = nrp_pkg::ModeIdle;
               byte_pos_in = 16'd0;
            end
         end
      end

      // tag the final result of this transaction
      if (cnt != '0) begin
         step.item[cnt - 1'b1].last_of_step = 1'b1;
      end
      step.count = cnt;
      seq_in     = seq;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= nrp_pkg::ModeIdle;
         agg_open_ff  <= 1'b0;
         agg_len_ff   <= 16'd0;
         byte_pos_ff  <= 16'd0;
         unit_len_ff  <= 16'd0;
         fill_ff      <= 16'd0;
         unit_type_ff <= 6'd0;
         seq_ff       <= 16'd0;
      end else begin
         mode_ff      <= mode_in;
         agg_open_ff  <= agg_open_in;
         agg_len_ff   <= agg_len_in;
         byte_pos_ff  <= byte_pos_in;
         unit_len_ff  <= unit_len_in;
         fill_ff      <= fill_in;
         unit_type_ff <= unit_type_in;
         seq_ff       <= seq_in;
      end
   end

endmodule

// File: sv/nal_rtp_payload_packetizer.sv
// NAL unit RTP payload packetizer: request channel, result burst buffer and output register.
//
// Takes NAL units one byte per request transaction and returns RTP payload bytes (single,
// aggregation or fragment packets, no RTP header) one per result transaction. A request
// that causes one result is taken every cycle unless the result port stalls; one that causes
// up to 6 (at aggregation and fragment headers) holds the request side until its burst drains,
// since the result port moves one byte per cycle. The user must write the payload limit
// through the csr port only while the block is idle; the block does not enforce this.
module nal_rtp_payload_packetizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_nal,
   input  logic [15:0] req_nal_size,
   input  logic [15:0] req_next_size,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_packet_end,
   output logic [1:0]  rsp_packet_kind,
   output logic [15:0] rsp_seq_number,
   output logic        rsp_last_of_step,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_payload_limit
);

   logic [15:0]        limit_ff;
   logic               req_accept;
   logic               out_load;
   nrp_pkg::burst_type step;
   nrp_pkg::burst_type burst_ff, burst_in;
   logic [nrp_pkg::CountBits-1:0] count_ff, count_in;
   nrp_pkg::result_type out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   // Payload limit register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= nrp_pkg::ResetLimit;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_payload_limit;
      end
   end

   // A request is taken once the burst buffer drains this cycle
   assign out_load   = !out_valid_ff || rsp_ready;
   assign req_ready  = (count_ff == '0) ||
                       (count_ff == nrp_pkg::CountBits'(1) && out_load);
   assign req_accept = req_valid && req_ready;

   nrp_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .func         (req_func),
      .data_byte    (req_data_byte),
      .first_of_nal (req_first_of_nal),
      .nal_size     (req_nal_size),
      .next_size    (req_next_size),
      .limit        (limit_ff),
      .step         (step)
   );

   // Burst buffer shifts one result into the output register per cycle while the output can load
   always_comb begin
      burst_in     = burst_ff;
      count_in     = count_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = (count_ff != '0);
         out_in       = burst_ff.item[0];
         if (count_ff != '0) begin
            for (int i = 0; i < nrp_pkg::MaxResults - 1; i++) begin
               burst_in.item[i] = burst_ff.item[i+1];
            end
            count_in = count_ff - 1'b1;
         end
      end
      if (req_accept) begin
         burst_in = step;
         count_in = step.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
      out_ff   <= out_in;
   end

   // Result port
   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_ff.out_byte;
   assign rsp_byte_valid   = out_ff.byte_valid;
   assign rsp_packet_end   = out_ff.packet_end;
   assign rsp_packet_kind  = out_ff.packet_kind;
   assign rsp_seq_number   = out_ff.seq_number;
   assign rsp_last_of_step = out_ff.last_of_step;

   // A bare end marker only ever closes an aggregation packet, with a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |->
         rsp_packet_end && rsp_packet_kind == nrp_pkg::KindAgg && rsp_out_byte == 8'd0)
      else $error("bare end marker outside an aggregation close");

   // The burst buffer never holds more than one transaction's results
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= nrp_pkg::CountBits'(nrp_pkg::MaxResults))
      else $error("burst buffer overfilled");

   // The output register is filled only when the burst buffer had something to give
   assert property (@(posedge clock) disable iff (reset)
      out_load && count_ff == '0 |=> !rsp_valid)
      else $error("result shown with nothing pending");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the NAL unit RTP payload packetizer.
`timescale 1ns / 100ps

module tb;

   // Predicts the payload bytes of each accepted request and checks the result stream
   class payload_scoreboard;
      nrp_pkg::result_type results_due[$];
      int                  errors;
      logic [15:0]         limit;
      nrp_pkg::mode_type   mode;
      logic                agg_open;
      logic [15:0]         agg_len;
      logic [15:0]         byte_pos;
      logic [15:0]         unit_len;
      logic [15:0]         frag_fill;
      logic [5:0]          unit_type;
      logic [15:0]         seq;

      function new();
         errors    = 0;
         limit     = nrp_pkg::ResetLimit;
         mode      = nrp_pkg::ModeIdle;
         agg_open  = 1'b0;
         agg_len   = '0;
         byte_pos  = '0;
         unit_len  = '0;
         frag_fill = '0;
         unit_type = '0;
         seq       = '0;
      endfunction

      function void set_limit(logic [15:0] value);
         limit = value;
      endfunction

      // Limits below the floor act as the floor
      function int payload_cap();
         return (limit < nrp_pkg::MinLimit) ? int'(nrp_pkg::MinLimit) : int'(limit);
      endfunction

      function void emit(logic [7:0] b, logic valid, logic pend, logic [1:0] kind);
         nrp_pkg::result_type r;
         r.out_byte     = b;
         r.byte_valid   = valid;
         r.packet_end   = pend;
         r.packet_kind  = kind;
         r.seq_number   = seq;
         r.last_of_step = 1'b0;
         results_due = {results_due, r};
      endfunction

      // Bare end marker closes the open aggregation packet
      function void close_agg();
         emit(8'd0, 1'b0, 1'b1, nrp_pkg::KindAgg);
         seq      = seq + 16'd1;
         agg_open = 1'b0;
         agg_len  = '0;
      endfunction

      // FU indicator, FU type and S/E/type byte of a fragment
      function void fragment_header(logic start, int first_data);
         logic   last;
         last = (int'(unit_len) - first_data) <= (payload_cap() - 3);
         emit(8'd0, 1'b1, 1'b0, nrp_pkg::KindFrag);
         emit(nrp_pkg::FuType, 1'b1, 1'b0, nrp_pkg::KindFrag);
         emit((start ? nrp_pkg::SBit : 8'd0) | (last ? nrp_pkg::EBit : 8'd0) |
              {2'b00, unit_type}, 1'b1, 1'b0, nrp_pkg::KindFrag);
         frag_fill = '0;
      endfunction

      // First byte of a unit picks single, aggregation or fragmentation
      function void open_unit(logic [7:0] b, int n, int nx);
         int cap;
         cap      = payload_cap();
         unit_len = 16'(n);
         byte_pos = 16'd1;
         if (n >= cap) begin
            if (agg_open) close_agg();
            mode      = nrp_pkg::ModeFrag;
            frag_fill = '0;
            return;
         end
         if (agg_open && (agg_len + 2 + n > cap)) close_agg();
         if (!agg_open && nx != 0 && 6 + n + nx <= cap) begin
            emit(8'd0, 1'b1, 1'b0, nrp_pkg::KindAgg);
            emit(nrp_pkg::ApType, 1'b1, 1'b0, nrp_pkg::KindAgg);
            agg_open = 1'b1;
            agg_len  = 16'd2;
         end
         if (agg_open) begin
            emit(8'(n >> 8), 1'b1, 1'b0, nrp_pkg::KindAgg);
            emit(8'(n), 1'b1, 1'b0, nrp_pkg::KindAgg);
            emit(b, 1'b1, 1'b0, nrp_pkg::KindAgg);
            agg_len = 16'(agg_len + 2 + n);
            mode    = (n == 1) ? nrp_pkg::ModeIdle : nrp_pkg::ModeAgg;
         end else if (n == 1) begin
            emit(b, 1'b1, 1'b1, nrp_pkg::KindSingle);
            seq  = seq + 16'd1;
            mode = nrp_pkg::ModeIdle;
         end else begin
            emit(b, 1'b1, 1'b0, nrp_pkg::KindSingle);
            mode = nrp_pkg::ModeSingle;
         end
      endfunction

      // Any later byte of the unit in progress
      function void unit_byte(logic [7:0] b);
         int   pos;
         logic done;
         pos  = int'(byte_pos);
         done = (pos + 1 >= int'(unit_len));
         if (mode == nrp_pkg::ModeSingle) begin
            emit(b, 1'b1, done, nrp_pkg::KindSingle);
            if (done) seq = seq + 16'd1;
         end else if (mode == nrp_pkg::ModeAgg) begin
            emit(b, 1'b1, 1'b0, nrp_pkg::KindAgg);
         end else if (pos == 0) begin
            // first unit header byte of a fragmented unit is dropped
         end else if (pos == 1) begin
            // second unit header byte carries the type; first fragment headers go out here
            unit_type = 6'(b & nrp_pkg::TypeMask);
            fragment_header(1'b1, 2);
         end else begin
            frag_fill = frag_fill + 16'd1;
            if (done) begin
               emit(b, 1'b1, 1'b1, nrp_pkg::KindFrag);
               seq       = seq + 16'd1;
               frag_fill = '0;
            end else if (frag_fill >= payload_cap() - 3) begin
               emit(b, 1'b1, 1'b1, nrp_pkg::KindFrag);
               seq = seq + 16'd1;
               fragment_header(1'b0, pos + 1);
            end else begin
               emit(b, 1'b1, 1'b0, nrp_pkg::KindFrag);
            end
         end
         byte_pos = 16'(pos + 1);
         if (done) begin
            mode     = nrp_pkg::ModeIdle;
            byte_pos = '0;
         end
      endfunction

      function void note_request(logic func, logic [7:0] b, logic first,
                                 logic [15:0] nal_size, logic [15:0] next_size);
         int start;
         int n;
         int nx;
         start = results_due.size();
         n     = int'(nal_size & nrp_pkg::SizeMask);
         nx    = int'(next_size & nrp_pkg::SizeMask);
         if (n == 0) n = 1;
         if (func == nrp_pkg::FuncFlush) begin
            if (mode == nrp_pkg::ModeIdle && agg_open) close_agg();
         end else if (mode == nrp_pkg::ModeIdle) begin
            if (first) open_unit(b, n, nx);
         end else begin
            unit_byte(b);
         end
         if (results_due.size() > start)
            results_due[results_due.size()-1].last_of_step = 1'b1;
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
         end
      endfunction

      function void check_result(nrp_pkg::result_type got);
         nrp_pkg::result_type want;
         if (results_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual 0x%h", $time, got);
            return;
         end
         want = results_due.pop_front();
         compare_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
         compare_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
         compare_field("packet_end", 16'(want.packet_end), 16'(got.packet_end));
         compare_field("packet_kind", 16'(want.packet_kind), 16'(got.packet_kind));
         compare_field("seq_number", want.seq_number, got.seq_number);
         compare_field("last_of_step", 16'(want.last_of_step), 16'(got.last_of_step));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = nrp_pkg::FuncData;
   logic [7:0]  req_data_byte = '0;
   logic        req_first_of_nal = 1'b0;
   logic [15:0] req_nal_size = '0;
   logic [15:0] req_next_size = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_packet_end;
   logic [1:0]  rsp_packet_kind;
   logic [15:0] rsp_seq_number;
   logic        rsp_last_of_step;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_payload_limit = '0;

   payload_scoreboard sb = new();
   bit steady = 1'b0;
   int cap_now = int'(nrp_pkg::ResetLimit);

   nal_rtp_payload_packetizer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .req_first_of_nal (req_first_of_nal),
      .req_nal_size     (req_nal_size),
      .req_next_size    (req_next_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_packet_kind  (rsp_packet_kind),
      .rsp_seq_number   (rsp_seq_number),
      .rsp_last_of_step (rsp_last_of_step),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_payload_limit(csr_payload_limit)
   );

   always #6 clock = ~clock;

   // Result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 36);
   end

   // Result monitor
   always @(posedge clock) begin
      nrp_pkg::result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.out_byte     = rsp_out_byte;
         got.byte_valid   = rsp_byte_valid;
         got.packet_end   = rsp_packet_end;
         got.packet_kind  = rsp_packet_kind;
         got.seq_number   = rsp_seq_number;
         got.last_of_step = rsp_last_of_step;
         sb.check_result(got);
      end
   end

   // One request transaction, with random idle cycles ahead of it outside steady stretches
   task automatic send_item(input logic func, input logic [7:0] data, input logic first,
                            input logic [15:0] nal_size, input logic [15:0] next_size);
      while (!steady && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_data_byte    <= data;
      req_first_of_nal <= first;
      req_nal_size     <= nal_size;
      req_next_size    <= next_size;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(func, data, first, nal_size, next_size);
   endtask

   // A whole NAL unit; later bytes carry junk sizes, a stray first mark or a flush now and then
   task automatic send_unit(input int size, input int next_size);
      int span;
      span = (size == 0) ? 1 : size;
      send_item(nrp_pkg::FuncData, 8'($urandom), 1'b1, 16'(size), 16'(next_size));
      for (int i = 1; i < span; i++) begin
         if ($urandom_range(99) < 4)
            send_item(nrp_pkg::FuncFlush, 8'($urandom), 1'($urandom), 16'($urandom),
                      16'($urandom));
         send_item(nrp_pkg::FuncData, 8'($urandom), $urandom_range(99) < 8,
                   16'($urandom), 16'($urandom));
      end
   endtask

   // Wait out every owed result plus the pipeline
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      csr_valid         <= 1'b1;
      csr_payload_limit <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_limit(value);
      cap_now = (value < nrp_pkg::MinLimit) ? int'(nrp_pkg::MinLimit) : int'(value);
      csr_valid <= 1'b0;
   endtask

   // Mostly small units, sometimes one that needs fragmenting
   function automatic int unit_size();
      int pick;
      pick = $urandom_range(99);
      if (pick < 22 && cap_now <= 48) return $urandom_range(cap_now, 2 * cap_now + 4);
      if (pick < 32) return 1;
      return $urandom_range(2, (cap_now - 1 < 24) ? cap_now - 1 : 24);
   endfunction

   // Units with announced next sizes, plus flushes, stray bytes and zero sizes
   task automatic random_phase(input int budget);
      int sent;
      int pick;
      int size;
      int next_size;
      int ahead;
      sent  = 0;
      ahead = 0;
      while (sent < budget) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_item(nrp_pkg::FuncFlush, 8'($urandom), 1'($urandom), 16'($urandom),
                      16'($urandom));
         end else if (pick < 14) begin
            send_item(nrp_pkg::FuncData, 8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
         end else begin
            size = (ahead != 0) ? ahead : unit_size();
            if ($urandom_range(19) == 0) size = 0;
            pick = $urandom_range(99);
            if (pick < 50) next_size = unit_size();
            else if (pick < 60) next_size = $urandom_range(65535);
            else next_size = 0;
            ahead = (pick < 50) ? next_size : 0;
            send_unit(size, next_size);
            sent += (size == 0) ? 1 : size;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset limit, stray byte, empty flush, one-byte and zero-size units
      send_item(nrp_pkg::FuncData, 8'hA5, 1'b0, 16'hFFFF, 16'hFFFF);
      send_item(nrp_pkg::FuncFlush, 8'h00, 1'b0, 16'h1234, 16'h0000);
      send_item(nrp_pkg::FuncData, 8'hFF, 1'b1, 16'd1, 16'd0);
      send_item(nrp_pkg::FuncData, 8'h00, 1'b1, 16'd0, 16'd0);
      // aggregation of two units closed by a flush
      send_item(nrp_pkg::FuncData, 8'h40, 1'b1, 16'd2, 16'd1);
      send_item(nrp_pkg::FuncData, 8'hFF, 1'b0, 16'h0000, 16'h0000);
      send_item(nrp_pkg::FuncData, 8'h00, 1'b1, 16'd1, 16'hFFFF);
      send_item(nrp_pkg::FuncFlush, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
      // single unit with a flush and a repeated first mark inside it
      send_item(nrp_pkg::FuncData, 8'h12, 1'b1, 16'd3, 16'd0);
      send_item(nrp_pkg::FuncFlush, 8'h00, 1'b0, 16'd0, 16'd0);
      send_item(nrp_pkg::FuncData, 8'h34, 1'b1, 16'hFFFF, 16'hFFFF);
      send_item(nrp_pkg::FuncData, 8'h56, 1'b0, 16'd0, 16'd0);
      settle();

      // Limit below the floor; aggregation closed by a unit that must be fragmented
      write_limit(16'd0);
      send_item(nrp_pkg::FuncData, 8'h26, 1'b1, 16'd2, 16'd3);
      send_item(nrp_pkg::FuncData, 8'h01, 1'b0, 16'd0, 16'd0);
      send_unit(16, 0);
      settle();

      write_limit(nrp_pkg::MinLimit);
      random_phase(12);
      settle();

      write_limit(16'($urandom_range(17, 48)));
      random_phase(12);
      settle();

      // no idling on either side through this stretch
      steady = 1'b1;
      write_limit(16'hFFFF);
      random_phase(12);
      settle();
      steady = 1'b0;

      write_limit(nrp_pkg::ResetLimit);
      random_phase(12);
      settle();

      if (sb.errors == 0 && sb.results_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
